@@ hdl/ucrr_pkg.sv @@
// ----------------------------------------------------------------------------
// ucrr_pkg: shared types and constants of the EP0 request responder
// Result kinds, request codes, controller states and the descriptor byte table.
// ----------------------------------------------------------------------------
package ucrr_pkg;

	localparam int MAX_PACKET   = 64;
	localparam int STRING_COUNT = 5;
	localparam int CFG_TOTAL    = 32;

	localparam logic [2:0] KIND_DATA    = 3'd0;
	localparam logic [2:0] KIND_ZLP     = 3'd1;
	localparam logic [2:0] KIND_ARM_OUT = 3'd2;
	localparam logic [2:0] KIND_ADDR    = 3'd3;
	localparam logic [2:0] KIND_UNHAND  = 3'd4;
	localparam logic [2:0] KIND_RESET   = 3'd5;

	localparam logic [1:0] TYPE_SETUP   = 2'd0;
	localparam logic [1:0] TYPE_IN_DONE = 2'd1;
	localparam logic [1:0] TYPE_BUS_RST = 2'd2;
	localparam logic [1:0] TYPE_IGNORED = 2'd3;

	localparam logic [7:0] RQ_SET_ADDRESS = 8'd5;
	localparam logic [7:0] RQ_GET_DESC    = 8'd6;
	localparam logic [7:0] RQ_GET_CONFIG  = 8'd8;
	localparam logic [7:0] RQ_SET_CONFIG  = 8'd9;

	localparam logic [7:0] DIR_OUT = 8'h00;
	localparam logic [7:0] DIR_IN  = 8'h80;

	localparam logic [1:0] CFG_VENDOR  = 2'd0;
	localparam logic [1:0] CFG_PRODUCT = 2'd1;
	localparam logic [1:0] CFG_RELEASE = 2'd2;
	localparam logic [1:0] CFG_POWER   = 2'd3;

	// source selected for a data stage
	typedef enum logic [2:0] {
		SRC_DEVICE, SRC_CONFIG, SRC_LANG, SRC_STRING, SRC_ONE
	} src_t;

	typedef enum logic [1:0] {
		ST_IDLE, ST_EMIT, ST_STREAM
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       load;      // capture a new decoded item
		logic       advance;   // step byte counter
		logic       emit;      // present result to output register
		logic       last;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       stream;    // item produces a data stage
		logic       final_byte;
		logic       drop;      // presented item yields no result
	} dp_sts_t;

	// string characters: 8 per string, index (s*8+i)
	function automatic logic [7:0] str_char(input logic [2:0] s, input logic [2:0] i);
		logic [7:0] c;
		c = 8'h00;
		case ({s, i})
			6'o00: c = 8'h50; 6'o01: c = 8'h69; 6'o02: c = 8'h63; 6'o03: c = 8'h6f;
			6'o04: c = 8'h55; 6'o05: c = 8'h53; 6'o06: c = 8'h42;
			6'o10: c = 8'h44; 6'o11: c = 8'h65; 6'o12: c = 8'h6d; 6'o13: c = 8'h6f;
			6'o20: c = 8'h31; 6'o21: c = 8'h32; 6'o22: c = 8'h33; 6'o23: c = 8'h34;
			6'o24: c = 8'h35;
			6'o30: c = 8'h53; 6'o31: c = 8'h69; 6'o32: c = 8'h6d; 6'o33: c = 8'h70;
			6'o34: c = 8'h6c; 6'o35: c = 8'h65;
			6'o40: c = 8'h42; 6'o41: c = 8'h61; 6'o42: c = 8'h73; 6'o43: c = 8'h69;
			6'o44: c = 8'h63;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [3:0] str_len(input logic [2:0] s);
		logic [3:0] l;
		case (s)
			3'd0: l = 4'd7;
			3'd1: l = 4'd4;
			3'd2: l = 4'd5;
			3'd3: l = 4'd6;
			3'd4: l = 4'd5;
			default: l = 4'd0;
		endcase
		return l;
	endfunction

	function automatic logic [7:0] cfg_byte(input logic [4:0] k, input logic [7:0] power);
		logic [7:0] b;
		case (k)
			5'd0: b = 8'd9;   5'd1: b = 8'h02; 5'd2: b = 8'd32; 5'd3: b = 8'd0;
			5'd4: b = 8'd1;   5'd5: b = 8'd1;  5'd6: b = 8'd4;  5'd7: b = 8'hc0;
			5'd8: b = power;
			5'd9: b = 8'd9;   5'd10: b = 8'h04; 5'd11: b = 8'd0; 5'd12: b = 8'd0;
			5'd13: b = 8'd2;  5'd14: b = 8'hff; 5'd15: b = 8'd0; 5'd16: b = 8'd0;
			5'd17: b = 8'd5;
			5'd18: b = 8'd7;  5'd19: b = 8'h05; 5'd20: b = 8'h01; 5'd21: b = 8'h02;
			5'd22: b = 8'd64; 5'd23: b = 8'd0;  5'd24: b = 8'd0;
			5'd25: b = 8'd7;  5'd26: b = 8'h05; 5'd27: b = 8'h82; 5'd28: b = 8'h02;
			5'd29: b = 8'd64; 5'd30: b = 8'd0;  5'd31: b = 8'd0;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

@@ hdl/ucrr_ctrl.sv @@
// ----------------------------------------------------------------------------
// ucrr_ctrl: sequencer of the EP0 responder
// Accepts one item, then issues one result or a run of data bytes; an ignored item yields no result.
// ----------------------------------------------------------------------------
module ucrr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output ucrr_pkg::dp_cmd_t cmd,
	input  ucrr_pkg::dp_sts_t sts
);
	import ucrr_pkg::*;

	state_t state_q, state_d;
	logic   busy_out;

	assign busy_out = out_valid && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd         = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				// drop an item that yields no result: take it and stay idle
				if (in_valid && !sts.drop) begin
					cmd.load = 1'b1;
					state_d  = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!busy_out) begin
					cmd.emit = 1'b1;
					if (sts.stream && !sts.final_byte) begin
						cmd.advance = 1'b1;
						state_d     = ST_STREAM;
					end else begin
						cmd.last = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			ST_STREAM: begin
				if (!busy_out) begin
					cmd.emit = 1'b1;
					if (sts.final_byte) begin
						cmd.last = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// output register valid: set on emit, drop when taken
	logic valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end
	assign out_valid = valid_q;

endmodule

@@ hdl/ucrr_dp.sv @@
// ----------------------------------------------------------------------------
// ucrr_dp: datapath of the EP0 responder
// Holds device state and config, decodes requests, builds each result.
// ----------------------------------------------------------------------------
module ucrr_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic [1:0]        req_type,
	input  logic [7:0]        request_kind,
	input  logic [7:0]        request_code,
	input  logic [15:0]       request_value,
	input  logic [15:0]       request_length,
	input  ucrr_pkg::dp_cmd_t cmd,
	output ucrr_pkg::dp_sts_t sts,
	output logic [2:0]        resp_kind,
	output logic [7:0]        resp_byte,
	output logic [6:0]        packet_len,
	output logic              data_pid,
	output logic              last_of_run,
	output logic [6:0]        current_address,
	output logic              configured_flag
);
	import ucrr_pkg::*;

	logic [15:0] vendor_q, product_q, release_q;
	logic [7:0]  power_q;
	logic        in_tog_q, out_tog_q, addr_pend_q, cfgd_q;
	logic [6:0]  pend_addr_q, act_addr_q;

	// captured item
	logic        stream_q;
	logic [2:0]  kind_q;
	logic        pid_q;
	src_t        src_q;
	logic [2:0]  sidx_q;
	logic [5:0]  n_q;      // bytes in run, 1..32
	logic [5:0]  pos_q;

	// decode of the presented item
	logic        d_stream;
	logic [2:0]  d_kind;
	logic        d_pid;
	src_t        d_src;
	logic [5:0]  d_avail;
	logic [5:0]  d_n;
	logic [7:0]  idx;
	logic [7:0]  dtype;
	logic [2:0]  sidx;

	assign dtype = request_value[15:8];
	assign idx   = request_value[7:0];
	assign sidx  = idx[2:0] - 3'd1;

	always_comb begin
		d_stream = 1'b0;
		d_kind   = KIND_UNHAND;
		d_pid    = 1'b0;
		d_src    = SRC_ONE;
		d_avail  = 6'd1;
		case (req_type)
			TYPE_SETUP: begin
				if (request_kind == DIR_OUT) begin
					d_kind = KIND_ZLP;
					d_pid  = 1'b1;
				end else if (request_kind == DIR_IN && request_code == RQ_GET_DESC) begin
					if (dtype == 8'd1) begin
						d_stream = 1'b1; d_src = SRC_DEVICE; d_avail = 6'd18;
					end else if (dtype == 8'd2) begin
						d_stream = 1'b1; d_src = SRC_CONFIG;
						d_avail  = (request_length >= 16'(CFG_TOTAL)) ? 6'd32 : 6'd9;
					end else if (dtype == 8'd3 && idx == 8'd0) begin
						d_stream = 1'b1; d_src = SRC_LANG; d_avail = 6'd4;
					end else if (dtype == 8'd3 && idx <= 8'(STRING_COUNT) && idx <= 8'd5) begin
						d_stream = 1'b1; d_src = SRC_STRING;
						d_avail  = 6'(5'd2 + {str_len(sidx), 1'b0});
					end
				end else if (request_kind == DIR_IN && request_code == RQ_GET_CONFIG) begin
					d_stream = 1'b1; d_src = SRC_ONE; d_avail = 6'd1;
				end
				if (d_stream) begin
					d_pid = 1'b1;
					if (request_length == 16'd0) begin
						d_stream = 1'b0;
						d_kind   = KIND_ZLP;
					end else begin
						d_kind = KIND_DATA;
					end
				end
			end
			TYPE_IN_DONE: begin
				d_kind = addr_pend_q ? KIND_ADDR : KIND_ARM_OUT;
				d_pid  = addr_pend_q ? 1'b0 : out_tog_q;
			end
			default: d_kind = KIND_RESET;
		endcase
		d_n = (request_length < {10'd0, d_avail}) ? request_length[5:0] : d_avail;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vendor_q <= 16'd0; product_q <= 16'd1; release_q <= 16'd1; power_q <= 8'd50;
			in_tog_q <= 1'b0; out_tog_q <= 1'b0; addr_pend_q <= 1'b0; cfgd_q <= 1'b0;
			pend_addr_q <= 7'd0; act_addr_q <= 7'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_VENDOR:  vendor_q  <= cfg_data;
					CFG_PRODUCT: product_q <= cfg_data;
					CFG_RELEASE: release_q <= cfg_data;
					CFG_POWER:   power_q   <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				case (req_type)
					TYPE_SETUP: begin
						// any setup leaves the IN toggle at 0 unless unhandled
						in_tog_q <= (d_stream || d_kind == KIND_ZLP) ? 1'b0 : 1'b1;
						if (request_kind == DIR_OUT) begin
							if (request_code == RQ_SET_ADDRESS) begin
								pend_addr_q <= request_value[6:0];
								addr_pend_q <= 1'b1;
							end else if (request_code == RQ_SET_CONFIG) begin
								cfgd_q <= 1'b1;
							end
						end
					end
					TYPE_IN_DONE: begin
						if (addr_pend_q) begin
							act_addr_q  <= pend_addr_q;
							addr_pend_q <= 1'b0;
						end else begin
							out_tog_q <= ~out_tog_q;
						end
					end
					TYPE_BUS_RST: begin
						pend_addr_q <= 7'd0; act_addr_q <= 7'd0;
						addr_pend_q <= 1'b0; cfgd_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			stream_q <= d_stream;
			kind_q   <= d_kind;
			pid_q    <= d_pid;
			src_q    <= d_src;
			sidx_q   <= sidx;
			n_q      <= d_n;
			pos_q    <= 6'd0;
		end else if (cmd.advance) begin
			pos_q <= pos_q + 6'd1;
		end
	end

	assign sts.stream     = stream_q;
	assign sts.final_byte = (pos_q + 6'd1 == n_q);
	assign sts.drop       = (req_type == TYPE_IGNORED);

	logic [7:0] byte_w;
	always_comb begin
		byte_w = 8'd0;
		case (src_q)
			SRC_DEVICE: begin
				case (pos_q[4:0])
					5'd0: byte_w = 8'd18;  5'd1: byte_w = 8'h01; 5'd2: byte_w = 8'h00;
					5'd3: byte_w = 8'h02;  5'd7: byte_w = 8'(MAX_PACKET);
					5'd8: byte_w = vendor_q[7:0];   5'd9: byte_w = vendor_q[15:8];
					5'd10: byte_w = product_q[7:0]; 5'd11: byte_w = product_q[15:8];
					5'd12: byte_w = release_q[7:0]; 5'd13: byte_w = release_q[15:8];
					5'd14: byte_w = 8'd1; 5'd15: byte_w = 8'd2; 5'd16: byte_w = 8'd3;
					5'd17: byte_w = 8'd1;
					default: byte_w = 8'd0;
				endcase
			end
			SRC_CONFIG: byte_w = cfg_byte(pos_q[4:0], power_q);
			SRC_LANG: begin
				case (pos_q[1:0])
					2'd0: byte_w = 8'd4; 2'd1: byte_w = 8'h03;
					2'd2: byte_w = 8'h09; default: byte_w = 8'h04;
				endcase
			end
			SRC_STRING: begin
				if (pos_q == 6'd0) byte_w = {3'd0, str_len(sidx_q), 1'b0} + 8'd2;
				else if (pos_q == 6'd1) byte_w = 8'h03;
				else if (pos_q[0]) byte_w = 8'h00;
				else byte_w = str_char(sidx_q, 3'(pos_q[4:1] - 4'd1));
			end
			SRC_ONE: byte_w = 8'h01;
			default: byte_w = 8'd0;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			resp_kind       <= kind_q;
			resp_byte       <= stream_q ? byte_w : 8'd0;
			packet_len      <= stream_q ? {1'b0, n_q} : 7'd0;
			data_pid        <= pid_q;
			last_of_run     <= cmd.last;
			current_address <= act_addr_q;
			configured_flag <= cfgd_q;
		end
	end

endmodule

@@ hdl/usb_control_request_responder_top.sv @@
// ----------------------------------------------------------------------------
// usb_control_request_responder_top: USB 2.0 EP0 standard request responder
// The item is captured at the input transfer; its first result then goes to the output register.
// Throughput: one result per cycle while m_axis_tready stays high; a new item is
// taken only after the controller has emitted every result of the previous one.
// Reset (arst_n low): toggles, address, configured flag and config registers to defaults.
// ----------------------------------------------------------------------------
module usb_control_request_responder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// req_type[1:0], request_kind[9:2], request_code[17:10],
	// request_value[33:18], request_length[49:34], zero fill to 56
	input  logic [55:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// resp_kind[2:0], resp_byte[10:3], packet_len[17:11], data_pid[18],
	// current_address[25:19], configured_flag[26], zero fill to 32
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tlast
);
	import ucrr_pkg::*;

	dp_cmd_t    cmd;
	dp_sts_t    sts;
	logic [2:0] resp_kind;
	logic [7:0] resp_byte;
	logic [6:0] packet_len, current_address;
	logic       data_pid, configured_flag;

	ucrr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.cmd(cmd), .sts(sts)
	);

	ucrr_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_type(s_axis_tdata[1:0]), .request_kind(s_axis_tdata[9:2]),
		.request_code(s_axis_tdata[17:10]), .request_value(s_axis_tdata[33:18]),
		.request_length(s_axis_tdata[49:34]),
		.cmd(cmd), .sts(sts),
		.resp_kind(resp_kind), .resp_byte(resp_byte), .packet_len(packet_len),
		.data_pid(data_pid), .last_of_run(m_axis_tlast),
		.current_address(current_address), .configured_flag(configured_flag)
	);

	assign m_axis_tdata = {5'd0, configured_flag, current_address, data_pid,
		packet_len, resp_byte, resp_kind};

endmodule
